FILE: design/acc_pkg.sv
// Shared types, codes and lookup functions for the alarm clock controller.
package acc_pkg;

    // Time of day in seconds, always below one day.
    localparam int unsigned TIME_W = 17;
    localparam logic [TIME_W-1:0] DAY_SECONDS = 17'd86400;
    localparam logic [TIME_W-1:0] LAST_SECOND = 17'd86399;

    // Reciprocal constants: x / 60 = (x * DIV60_MUL) >> DIV60_SHIFT, and the same for
    // 3600. Both are exact for every x below 2**17.
    localparam logic [17:0] DIV60_MUL     = 18'd139811;
    localparam int unsigned DIV60_SHIFT   = 23;
    localparam logic [17:0] DIV3600_MUL   = 18'd149131;
    localparam int unsigned DIV3600_SHIFT = 29;

    // Event kinds.
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_BUTTONS = 1'b1;

    // Button codes.
    localparam logic [3:0] BTN_NONE   = 4'd0;
    localparam logic [3:0] BTN_DOWN   = 4'd1;
    localparam logic [3:0] BTN_UP     = 4'd2;
    localparam logic [3:0] BTN_CURSOR = 4'd4;
    localparam logic [3:0] BTN_MODE   = 4'd8;
    localparam logic [3:0] BTN_RESET_VALUE = 4'd15;

    localparam logic [7:0] SEG_BLANK = 8'hFF;
    localparam logic [7:0] LED_ON    = 8'hFF;
    localparam logic [7:0] LED_OFF   = 8'h00;

    // Operating modes, one-hot.
    typedef enum logic [2:0] {
        MODE_RUN       = 3'b001,
        MODE_SET_TIME  = 3'b010,
        MODE_SET_ALARM = 3'b100
    } mode_t;

    // Input transaction.
    typedef struct packed {
        logic       command;
        logic [3:0] buttons;
    } in_item_t;

    // Result transaction.
    typedef struct packed {
        logic [7:0] sec_units_seg;
        logic [7:0] sec_tens_seg;
        logic [7:0] min_units_seg;
        logic [7:0] min_tens_seg;
        logic [7:0] hour_units_seg;
        logic [7:0] hour_tens_seg;
        logic [7:0] led_pattern;
    } out_item_t;

    // Active-low seven-segment pattern of one decimal digit, blank above nine.
    function automatic logic [7:0] digit_seg(input logic [3:0] d);
        logic [6:0] code;
        code = 7'h7F;
        unique case (d)
            4'd0: code = 7'h40;
            4'd1: code = 7'h79;
            4'd2: code = 7'h24;
            4'd3: code = 7'h30;
            4'd4: code = 7'h19;
            4'd5: code = 7'h12;
            4'd6: code = 7'h02;
            4'd7: code = 7'h78;
            4'd8: code = 7'h00;
            4'd9: code = 7'h10;
            default: code = 7'h7F;
        endcase
        return {1'b1, code};
    endfunction

    // Adjustment step selected by the cursor.
    function automatic logic [TIME_W-1:0] cursor_step(input logic [1:0] c);
        logic [TIME_W-1:0] step;
        step = '0;
        unique case (c)
            2'd0: step = 17'd60;
            2'd1: step = 17'd600;
            2'd2: step = 17'd3600;
            2'd3: step = 17'd36000;
            default: step = 17'd60;
        endcase
        return step;
    endfunction

    // Tens digit of a value below 64: (v * 13) >> 7 is exact there.
    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [10:0] prod;
        prod = {5'd0, v} * 11'd13;
        return prod[10:7];
    endfunction

endpackage

FILE: design/alarm_clock_controller.sv
// Alarm clock controller: mode, time keeping, editing and display decoding.
//
// Usage: every input transaction on the s_ channel is one event, either a
// one-second tick (command 0) or a fresh sample of the four buttons
// (command 1). Every event yields exactly one result transaction on the m_
// channel carrying the six active-low digit patterns and the LED pattern as
// they stand after that event.
// An accepted event is held in the input register, processed into the result
// register when that register is free or being emptied, and is offered on
// m_valid from then on. Throughput is one event per cycle while m_ready
// is high; the next event needs only the state written by the one before.
// The digit split uses two constant reciprocal multipliers on the shown time
// and one on the alarm time, all in the single processing stage.
// The result register is also the display state, so a stalled receiver holds
// it; one further event may wait in the input register, and s_ready drops
// only while both registers are full and m_ready is low.
// Reset (aresetn low at a clock edge) selects run mode, clears all times,
// the cursor, the digits and the LEDs, and sets the last button sample to 15.
module alarm_clock_controller (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  acc_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output acc_pkg::out_item_t m_data
);

    // Input register.
    logic              in_valid_reg;
    acc_pkg::in_item_t in_item_reg;

    // Block state; digits_reg and led_reg double as the result register.
    acc_pkg::mode_t                 mode_reg, mode_next;
    logic [acc_pkg::TIME_W-1:0]     cur_reg, cur_next;
    logic [acc_pkg::TIME_W-1:0]     edit_reg, edit_next;
    logic [acc_pkg::TIME_W-1:0]     alarm_reg, alarm_next;
    logic [1:0]                     cursor_reg, cursor_next;
    logic [3:0]                     last_reg, last_next;
    logic [7:0]                     digits_reg [6];
    logic [7:0]                     digits_next [6];
    logic [7:0]                     led_reg, led_next;
    logic                           m_valid_reg;

    logic proc_fire;
    logic btn_changed;
    logic [acc_pkg::TIME_W-1:0] cur_inc, edit_inc, shown, step;
    logic [acc_pkg::TIME_W-1:0] sec_rem, min_rem;
    logic [34:0] min_prod, hour_prod, alarm_prod;
    logic [10:0] min_total, alarm_min;
    logic [4:0]  hours;
    logic [5:0]  minutes, seconds;
    logic [3:0]  sec_tens, min_tens, hour_tens;

    // Handshake: process when the result register is free or being emptied.
    assign proc_fire = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;
    assign m_valid   = m_valid_reg;

    // Wrapping increments of the running times.
    assign cur_inc  = (cur_reg == acc_pkg::LAST_SECOND) ? '0 : cur_reg + 17'd1;
    assign edit_inc = (edit_reg == acc_pkg::LAST_SECOND) ? '0 : edit_reg + 17'd1;

    // Time selected for display by a tick.
    always_comb begin
        unique case (mode_reg)
            acc_pkg::MODE_SET_TIME:  shown = edit_reg;
            acc_pkg::MODE_SET_ALARM: shown = alarm_reg;
            default:                 shown = cur_inc;
        endcase
    end

    // Split into hours, minutes and seconds by reciprocal multiplication.
    assign min_prod   = {18'd0, shown} * {17'd0, acc_pkg::DIV60_MUL};
    assign hour_prod  = {18'd0, shown} * {17'd0, acc_pkg::DIV3600_MUL};
    assign alarm_prod = {18'd0, alarm_reg} * {17'd0, acc_pkg::DIV60_MUL};
    assign min_total  = min_prod[acc_pkg::DIV60_SHIFT +: 11];
    assign hours      = hour_prod[acc_pkg::DIV3600_SHIFT +: 5];
    assign alarm_min  = alarm_prod[acc_pkg::DIV60_SHIFT +: 11];
    assign sec_rem    = shown - ({6'd0, min_total} * 17'd60);
    assign min_rem    = {6'd0, min_total} - ({12'd0, hours} * 17'd60);
    assign seconds    = sec_rem[5:0];
    assign minutes    = min_rem[5:0];
    assign sec_tens   = acc_pkg::tens_of(seconds);
    assign min_tens   = acc_pkg::tens_of(minutes);
    assign hour_tens  = acc_pkg::tens_of({1'b0, hours});

    assign btn_changed = (in_item_reg.buttons != last_reg);
    assign step        = acc_pkg::cursor_step(cursor_reg);

    // Add with wrap at one day; both operands are below one day.
    function automatic logic [acc_pkg::TIME_W-1:0] add_day(
        input logic [acc_pkg::TIME_W-1:0] t,
        input logic [acc_pkg::TIME_W-1:0] d
    );
        logic [acc_pkg::TIME_W:0] sum;
        sum = {1'b0, t} + {1'b0, d};
        if (sum >= {1'b0, acc_pkg::DAY_SECONDS}) begin
            sum = sum - {1'b0, acc_pkg::DAY_SECONDS};
        end
        return sum[acc_pkg::TIME_W-1:0];
    endfunction

    // Subtract, saturating at zero.
    function automatic logic [acc_pkg::TIME_W-1:0] sub_sat(
        input logic [acc_pkg::TIME_W-1:0] t,
        input logic [acc_pkg::TIME_W-1:0] d
    );
        return (t > d) ? (t - d) : '0;
    endfunction

    // Next state for the event in the input register.
    always_comb begin
        mode_next   = mode_reg;
        cur_next    = cur_reg;
        edit_next   = edit_reg;
        alarm_next  = alarm_reg;
        cursor_next = cursor_reg;
        last_next   = last_reg;
        led_next    = led_reg;
        for (int i = 0; i < 6; i++) begin
            digits_next[i] = digits_reg[i];
        end

        if (in_item_reg.command == acc_pkg::CMD_TICK) begin
            cur_next = cur_inc;
            digits_next[0] = acc_pkg::digit_seg(seconds[3:0] - 4'(sec_tens * 4'd10));
            digits_next[1] = acc_pkg::digit_seg(sec_tens);
            unique case (mode_reg)
                acc_pkg::MODE_SET_TIME:  edit_next = edit_inc;
                acc_pkg::MODE_SET_ALARM: ;
                default: begin
                    led_next = (!cur_inc[0] && (min_total == alarm_min)) ?
                               acc_pkg::LED_ON : acc_pkg::LED_OFF;
                end
            endcase
            // Blank the edited digit on odd blink seconds, else refresh all.
            if ((mode_reg == acc_pkg::MODE_SET_TIME && shown[0]) ||
                (mode_reg == acc_pkg::MODE_SET_ALARM && cur_inc[0])) begin
                digits_next[2 + int'(cursor_reg)] = acc_pkg::SEG_BLANK;
            end else begin
                digits_next[2] = acc_pkg::digit_seg(minutes[3:0] - 4'(min_tens * 4'd10));
                digits_next[3] = acc_pkg::digit_seg(min_tens);
                digits_next[4] = acc_pkg::digit_seg(hours[3:0] - 4'(hour_tens * 4'd10));
                digits_next[5] = acc_pkg::digit_seg(hour_tens);
            end
        end else begin
            last_next = in_item_reg.buttons;
            unique case (in_item_reg.buttons)
                acc_pkg::BTN_NONE: ;
                acc_pkg::BTN_MODE: begin
                    if (btn_changed) begin
                        unique case (mode_reg)
                            acc_pkg::MODE_RUN: begin
                                mode_next = acc_pkg::MODE_SET_TIME;
                                edit_next = cur_reg;
                            end
                            acc_pkg::MODE_SET_TIME: begin
                                mode_next = acc_pkg::MODE_SET_ALARM;
                                cur_next  = edit_reg;
                            end
                            default: mode_next = acc_pkg::MODE_RUN;
                        endcase
                    end
                end
                acc_pkg::BTN_CURSOR: begin
                    if (btn_changed) begin
                        cursor_next = cursor_reg + 2'd1;
                    end
                end
                acc_pkg::BTN_UP: begin
                    if (btn_changed) begin
                        unique case (mode_reg)
                            acc_pkg::MODE_SET_TIME:  edit_next  = add_day(edit_reg, step);
                            acc_pkg::MODE_SET_ALARM: alarm_next = add_day(alarm_reg, step);
                            default: ;
                        endcase
                    end
                end
                acc_pkg::BTN_DOWN: begin
                    if (btn_changed) begin
                        unique case (mode_reg)
                            acc_pkg::MODE_SET_TIME:  edit_next  = sub_sat(edit_reg, step);
                            acc_pkg::MODE_SET_ALARM: alarm_next = sub_sat(alarm_reg, step);
                            default: ;
                        endcase
                    end
                end
                default: mode_next = acc_pkg::MODE_RUN;
            endcase
        end
    end

    // Input register and handshake state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (proc_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_data;
        end
    end

    // Block state, updated once per processed transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= acc_pkg::MODE_RUN;
            cur_reg    <= '0;
            edit_reg   <= '0;
            alarm_reg  <= '0;
            cursor_reg <= '0;
            last_reg   <= acc_pkg::BTN_RESET_VALUE;
            led_reg    <= acc_pkg::LED_OFF;
            for (int i = 0; i < 6; i++) begin
                digits_reg[i] <= '0;
            end
        end else if (proc_fire) begin
            mode_reg   <= mode_next;
            cur_reg    <= cur_next;
            edit_reg   <= edit_next;
            alarm_reg  <= alarm_next;
            cursor_reg <= cursor_next;
            last_reg   <= last_next;
            led_reg    <= led_next;
            for (int i = 0; i < 6; i++) begin
                digits_reg[i] <= digits_next[i];
            end
        end
    end

    // Result payload.
    assign m_data.sec_units_seg  = digits_reg[0];
    assign m_data.sec_tens_seg   = digits_reg[1];
    assign m_data.min_units_seg  = digits_reg[2];
    assign m_data.min_tens_seg   = digits_reg[3];
    assign m_data.hour_units_seg = digits_reg[4];
    assign m_data.hour_tens_seg  = digits_reg[5];
    assign m_data.led_pattern    = led_reg;

    // All held times stay within one day.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_reg < acc_pkg::DAY_SECONDS) && (edit_reg < acc_pkg::DAY_SECONDS) &&
        (alarm_reg < acc_pkg::DAY_SECONDS))
        else $error("held time out of range");

    // The LEDs are either fully on or fully off.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (led_reg == acc_pkg::LED_ON) || (led_reg == acc_pkg::LED_OFF))
        else $error("invalid LED pattern");

    // A free result side never blocks the input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg || m_ready) |-> s_ready)
        else $error("input stalled with free result register");

    // A processed transaction always produces a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire |=> m_valid_reg)
        else $error("processed transaction lost");

    // State only moves when a transaction is processed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !proc_fire |=> $stable(cur_reg) && $stable(led_reg) && $stable(mode_reg))
        else $error("state changed without a transaction");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the alarm clock controller with a display-predicting scoreboard.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 8;
    localparam int TOTAL_EVENTS   = 1825;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int STALL_CYCLES   = 80;
    localparam int STALL_AFTER    = 400;
    localparam int MAX_PRINTED    = 40;
    localparam int DAY            = int'(acc_pkg::DAY_SECONDS);

    // Time of day in seconds.
    typedef logic [acc_pkg::TIME_W-1:0] secs_t;

    // Tracks the clock state and the display it must show after every event.
    class DisplayTracker;
        acc_pkg::mode_t     mode;
        secs_t              now_s;
        secs_t              edit_s;
        secs_t              alarm_s;
        logic [1:0]         cursor;
        logic [3:0]         last_btn;
        logic [7:0]         digits [6];
        logic [7:0]         leds;
        acc_pkg::out_item_t expected_displays [$];
        int                 errors;

        function new();
            mode     = acc_pkg::MODE_RUN;
            now_s    = '0;
            edit_s   = '0;
            alarm_s  = '0;
            cursor   = '0;
            last_btn = acc_pkg::BTN_RESET_VALUE;
            foreach (digits[i]) digits[i] = '0;
            leds     = acc_pkg::LED_OFF;
            errors   = 0;
        endfunction

        // Active-low pattern with the point segment off; anything above nine is blank.
        static function logic [7:0] seg_code_of(int d);
            logic [6:0] c;
            case (d)
                0: c = 7'h40;
                1: c = 7'h79;
                2: c = 7'h24;
                3: c = 7'h30;
                4: c = 7'h19;
                5: c = 7'h12;
                6: c = 7'h02;
                7: c = 7'h78;
                8: c = 7'h00;
                9: c = 7'h10;
                default: c = 7'h7F;
            endcase
            return 8'h80 | {1'b0, c};
        endfunction

        static function int step_of(logic [1:0] c);
            case (c)
                2'd0: return 60;
                2'd1: return 600;
                2'd2: return 3600;
                default: return 36000;
            endcase
        endfunction

        function void show_pair(int idx, int n);
            digits[idx]     = seg_code_of(n % 10);
            digits[idx + 1] = seg_code_of(n / 10);
        endfunction

        // One-second tick: the current time always advances.
        function void advance_second();
            int shown;
            bit full;
            full  = 1'b1;
            now_s = secs_t'((int'(now_s) + 1) % DAY);
            case (mode)
                acc_pkg::MODE_SET_TIME: begin
                    // The edit time is shown as it stood before this tick.
                    shown  = int'(edit_s);
                    edit_s = secs_t'((shown + 1) % DAY);
                    full   = (shown % 2) == 0;
                end
                acc_pkg::MODE_SET_ALARM: begin
                    shown = int'(alarm_s);
                    full  = (int'(now_s) % 2) == 0;
                end
                default: begin
                    shown = int'(now_s);
                    if ((shown % 2) == 0 && (shown / 60) == (int'(alarm_s) / 60))
                        leds = acc_pkg::LED_ON;
                    else
                        leds = acc_pkg::LED_OFF;
                end
            endcase
            show_pair(0, shown % 60);
            if (full) begin
                show_pair(2, (shown / 60) % 60);
                show_pair(4, shown / 3600);
            end else begin
                // Blink phase: only the digit under the cursor is blanked.
                digits[2 + cursor] = acc_pkg::SEG_BLANK;
            end
        endfunction

        // A button sample acts only on a change from the previous sample.
        function void apply_buttons(logic [3:0] b);
            bit changed;
            int step;
            changed = (b != last_btn);
            step    = step_of(cursor);
            case (b)
                acc_pkg::BTN_MODE: begin
                    if (changed) begin
                        case (mode)
                            acc_pkg::MODE_RUN: begin
                                mode   = acc_pkg::MODE_SET_TIME;
                                edit_s = now_s;
                            end
                            acc_pkg::MODE_SET_TIME: begin
                                mode  = acc_pkg::MODE_SET_ALARM;
                                now_s = edit_s;
                            end
                            default: mode = acc_pkg::MODE_RUN;
                        endcase
                    end
                end
                acc_pkg::BTN_CURSOR: begin
                    if (changed) cursor = cursor + 2'd1;
                end
                acc_pkg::BTN_UP: begin
                    if (changed) begin
                        if (mode == acc_pkg::MODE_SET_TIME)
                            edit_s = secs_t'((int'(edit_s) + step) % DAY);
                        else if (mode == acc_pkg::MODE_SET_ALARM)
                            alarm_s = secs_t'((int'(alarm_s) + step) % DAY);
                    end
                end
                acc_pkg::BTN_DOWN: begin
                    // Subtraction saturates at midnight instead of wrapping.
                    if (changed) begin
                        if (mode == acc_pkg::MODE_SET_TIME)
                            edit_s = (int'(edit_s) > step) ? secs_t'(int'(edit_s) - step) : '0;
                        else if (mode == acc_pkg::MODE_SET_ALARM)
                            alarm_s = (int'(alarm_s) > step) ?
                                      secs_t'(int'(alarm_s) - step) : '0;
                    end
                end
                acc_pkg::BTN_NONE: ;
                default: mode = acc_pkg::MODE_RUN;
            endcase
            last_btn = b;
        endfunction

        // Called for every accepted input transaction.
        function void note_event(acc_pkg::in_item_t ev);
            acc_pkg::out_item_t d;
            if (ev.command == acc_pkg::CMD_TICK)
                advance_second();
            else
                apply_buttons(ev.buttons);
            d.sec_units_seg  = digits[0];
            d.sec_tens_seg   = digits[1];
            d.min_units_seg  = digits[2];
            d.min_tens_seg   = digits[3];
            d.hour_units_seg = digits[4];
            d.hour_tens_seg  = digits[5];
            d.led_pattern    = leds;
            expected_displays.push_back(d);
        endfunction

        function int pending();
            return expected_displays.size();
        endfunction

        task report(string what);
            if (errors < MAX_PRINTED) $display("MISMATCH: %s", what);
            errors++;
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want) report($sformatf("%s got %02h expected %02h", name, got, want));
        endtask

        // Called for every accepted result transaction.
        task check_display(acc_pkg::out_item_t got);
            acc_pkg::out_item_t want;
            if (expected_displays.size() == 0) begin
                report("display update with no event pending");
                return;
            end
            want = expected_displays.pop_front();
            compare_field("sec_units_seg", got.sec_units_seg, want.sec_units_seg);
            compare_field("sec_tens_seg", got.sec_tens_seg, want.sec_tens_seg);
            compare_field("min_units_seg", got.min_units_seg, want.min_units_seg);
            compare_field("min_tens_seg", got.min_tens_seg, want.min_tens_seg);
            compare_field("hour_units_seg", got.hour_units_seg, want.hour_units_seg);
            compare_field("hour_tens_seg", got.hour_tens_seg, want.hour_tens_seg);
            compare_field("led_pattern", got.led_pattern, want.led_pattern);
        endtask
    endclass

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    acc_pkg::in_item_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    acc_pkg::out_item_t m_data;

    DisplayTracker tracker = new();
    int events_sent = 0;
    int burst_left  = 0;

    alarm_clock_controller u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Check every result transaction as it is accepted.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.check_display(m_data);
    end

    // Offer one event in bursts with random gaps and wait for its acceptance.
    task automatic send_item(acc_pkg::in_item_t ev);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= ev;
        do @(posedge aclk); while (!(s_valid && s_ready));
        tracker.note_event(ev);
        events_sent++;
        burst_left--;
    endtask

    task automatic push_buttons(logic [3:0] b);
        acc_pkg::in_item_t ev;
        ev.command = acc_pkg::CMD_BUTTONS;
        ev.buttons = b;
        send_item(ev);
    endtask

    // The button field of a tick is random so that it is seen to be ignored.
    task automatic send_tick();
        acc_pkg::in_item_t ev;
        ev.command = acc_pkg::CMD_TICK;
        ev.buttons = 4'($urandom_range(0, 15));
        send_item(ev);
    endtask

    // Press and release, so that the next press counts as a change.
    task automatic tap(logic [3:0] b);
        push_buttons(b);
        push_buttons(acc_pkg::BTN_NONE);
    endtask

    task automatic move_cursor(logic [1:0] target);
        while (tracker.cursor != target) tap(acc_pkg::BTN_CURSOR);
    endtask

    function automatic logic [3:0] any_edit_button();
        case ($urandom_range(0, 3))
            0: return acc_pkg::BTN_DOWN;
            1: return acc_pkg::BTN_UP;
            2: return acc_pkg::BTN_CURSOR;
            default: return acc_pkg::BTN_MODE;
        endcase
    endfunction

    // Set the clock to a minute before midnight, let it run up to or past midnight, and arm the alarm at midnight.
    task automatic roll_past_midnight();
        // All buttons at once is an illegal sample and forces run mode.
        push_buttons(acc_pkg::BTN_RESET_VALUE);
        tap(acc_pkg::BTN_MODE);
        move_cursor(2'd3);
        repeat (3) tap(acc_pkg::BTN_DOWN);
        repeat (2) tap(acc_pkg::BTN_UP);
        move_cursor(2'd2);
        repeat (3) tap(acc_pkg::BTN_UP);
        move_cursor(2'd1);
        repeat (5) tap(acc_pkg::BTN_UP);
        move_cursor(2'd0);
        repeat (9) tap(acc_pkg::BTN_UP);
        repeat ($urandom_range(50, 70)) send_tick();
        tap(acc_pkg::BTN_MODE);
        move_cursor(2'd3);
        repeat (3) tap(acc_pkg::BTN_DOWN);
        tap(acc_pkg::BTN_MODE);
        repeat ($urandom_range(40, 90)) send_tick();
    endtask

    // Receiver: changing stall patterns, plus one long hold-off to fill the block.
    initial begin : receiver
        int cyc;
        int style;
        bit stalled_once;
        cyc          = 0;
        style        = 0;
        stalled_once = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (!stalled_once && events_sent >= STALL_AFTER) begin
                stalled_once = 1'b1;
                m_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge aclk);
            end else begin
                if (cyc % 64 == 0) style = $urandom_range(0, 3);
                case (style)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (cyc % 5 != 0);
                endcase
                cyc++;
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle = 0;
            else
                idle++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Stimulus: reset, a directed walk through the modes, then random sequences.
    initial begin : stimulus
        int next_roll;
        int r;
        logic [3:0] b;
        next_roll = 600;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // The alarm still sits at midnight, so the LEDs light on the second even second.
        send_tick();
        send_tick();
        // Adjust buttons do nothing in run mode.
        push_buttons(acc_pkg::BTN_NONE);
        push_buttons(acc_pkg::BTN_DOWN);
        push_buttons(acc_pkg::BTN_NONE);
        push_buttons(acc_pkg::BTN_UP);
        // Enter set-time; a held mode button does not advance again.
        push_buttons(acc_pkg::BTN_MODE);
        push_buttons(acc_pkg::BTN_MODE);
        // Subtracting a minute from two seconds saturates at zero.
        push_buttons(acc_pkg::BTN_DOWN);
        send_tick();
        send_tick();
        // Add each step size in turn.
        push_buttons(acc_pkg::BTN_UP);
        push_buttons(acc_pkg::BTN_CURSOR);
        push_buttons(acc_pkg::BTN_UP);
        push_buttons(acc_pkg::BTN_CURSOR);
        push_buttons(acc_pkg::BTN_UP);
        push_buttons(acc_pkg::BTN_CURSOR);
        push_buttons(acc_pkg::BTN_UP);
        send_tick();
        send_tick();
        // Commit the edit and adjust the alarm with the largest step.
        push_buttons(acc_pkg::BTN_MODE);
        push_buttons(acc_pkg::BTN_DOWN);
        push_buttons(acc_pkg::BTN_UP);
        send_tick();
        send_tick();
        // Cursor wraps from the hour tens back to the minute units.
        push_buttons(acc_pkg::BTN_CURSOR);
        // Two buttons at once return to run mode.
        push_buttons(acc_pkg::BTN_UP | acc_pkg::BTN_DOWN);
        send_tick();

        // Random part: mostly clean presses and tick runs, some held and broken presses.
        while (events_sent < TOTAL_EVENTS) begin
            if (events_sent >= next_roll) begin
                roll_past_midnight();
                next_roll += 700;
            end else begin
                r = $urandom_range(0, 99);
                b = any_edit_button();
                if (r < 40) begin
                    tap(b);
                end else if (r < 72) begin
                    repeat ($urandom_range(1, 8)) send_tick();
                end else if (r < 82) begin
                    push_buttons(b);
                    push_buttons(b);
                    push_buttons(acc_pkg::BTN_NONE);
                end else if (r < 92) begin
                    push_buttons(4'($urandom_range(0, 15)));
                end else begin
                    push_buttons(b);
                end
            end
        end
        s_valid <= 1'b0;

        // Drain the remaining results, then allow for any stray output.
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

FILE: alarm_clock_controller.f
design/acc_pkg.sv
design/alarm_clock_controller.sv
tb/tb.sv
